// File: hw/rtl/mfep_pkg.sv
`timescale 1ns / 1ps

package mfep_pkg;

  localparam int PayloadHeadBytesDef = 5;
  localparam int DeltaMaxBytesDef    = 4;

  typedef enum logic [3:0] {
    PH_HEADER,
    PH_TRACK,
    PH_DELTA,
    PH_STATUS,
    PH_DATA1,
    PH_DATA2,
    PH_META_TYPE,
    PH_META_LEN,
    PH_META_PAY,
    PH_DONE,
    PH_HALT
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER      = 3'd0,
    KIND_TRACK_START = 3'd1,
    KIND_CHANNEL     = 3'd2,
    KIND_META        = 3'd3,
    KIND_END_TRACK   = 3'd4,
    KIND_ERROR       = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE         = 3'd0,
    ERR_BAD_ID       = 3'd1,
    ERR_FMT_TRACKS   = 3'd2,
    ERR_UNKNOWN_META = 3'd3,
    ERR_SYSEX        = 3'd4,
    ERR_BAD_STATUS   = 3'd5,
    ERR_LONG_DELTA   = 3'd6
  } err_e;

  // "MThd"
  localparam logic [7:0] HDR_ID [4] = '{8'h4D, 8'h54, 8'h68, 8'h64};

  localparam logic [7:0] ST_META       = 8'hFF;
  localparam logic [7:0] ST_SYSEX      = 8'hF0;
  localparam logic [7:0] ST_SYSEX_ESC  = 8'hF7;
  localparam logic [7:0] VLQ_MASK      = 8'h7F;

  localparam logic [7:0] META_SEQ_NAME = 8'h03;
  localparam logic [7:0] META_DEV_NAME = 8'h09;
  localparam logic [7:0] META_EOT      = 8'h2F;
  localparam logic [7:0] META_TEMPO    = 8'h51;
  localparam logic [7:0] META_SMPTE    = 8'h54;
  localparam logic [7:0] META_TIME_SIG = 8'h58;
  localparam logic [7:0] META_KEY_SIG  = 8'h59;

  function automatic logic meta_known(input logic [7:0] t);
    return (t == META_SMPTE) || (t == META_TIME_SIG) || (t == META_KEY_SIG) ||
           (t == META_TEMPO) || (t == META_EOT) || (t == META_DEV_NAME) ||
           (t == META_SEQ_NAME);
  endfunction

endpackage

// File: hw/rtl/midi_file_event_parser.sv
`timescale 1ns / 1ps
// channel | handshake                    | payload
// --------+------------------------------+----------------------------------------
// in      | in_valid_i / in_stall_o      | data_byte_i, start_of_file_i
// out     | out_valid_o / out_stall_i    | record_kind_o .. error_code_o
//
// one byte per cycle sustained while the output is not stalled; a byte is taken into the
// input register and its record, if any, is registered into the output register when it is parsed
// the whole parse step is one state machine update between the two registers
// reset puts the parser at the first header byte with both registers empty
// an output stall holds the record and stalls input only once the input register is full
module midi_file_event_parser
  import mfep_pkg::*;
#(
  parameter int PAYLOAD_HEAD_BYTES = PayloadHeadBytesDef,
  parameter int DELTA_MAX_BYTES    = DeltaMaxBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  record_kind_o,
  output logic [27:0] delta_time_o,
  output logic [7:0]  status_code_o,
  output logic [7:0]  data_first_o,
  output logic [7:0]  data_second_o,
  output logic [7:0]  meta_length_o,
  output logic [39:0] payload_head_o,
  output logic [31:0] chunk_length_o,
  output logic [15:0] file_format_o,
  output logic [15:0] track_count_o,
  output logic [15:0] tick_division_o,
  output logic [2:0]  error_code_o
);

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       sof_q;

  // parse state
  phase_e      phase_q, phase_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        id_ok_q, id_ok_d;
  logic [27:0] delta_q, delta_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  data1_q, data1_d;
  logic [7:0]  mlen_q, mlen_d;
  logic [39:0] pay_q, pay_d;
  logic [31:0] clen_q, clen_d;
  logic [47:0] hw_q, hw_d;
  logic [15:0] tleft_q, tleft_d;

  // output register
  logic        out_valid_q;
  kind_e       kind_q, kind_d;
  logic [27:0] o_delta_q, o_delta_d;
  logic [7:0]  o_status_q, o_status_d;
  logic [7:0]  o_data1_q, o_data1_d;
  logic [7:0]  o_data2_q, o_data2_d;
  logic [7:0]  o_mlen_q, o_mlen_d;
  logic [39:0] o_pay_q, o_pay_d;
  logic [31:0] o_clen_q, o_clen_d;
  logic [15:0] o_fmt_q, o_fmt_d;
  logic [15:0] o_ntrk_q, o_ntrk_d;
  logic [15:0] o_div_q, o_div_d;
  err_e        o_err_q, o_err_d;
  logic        emit;

  logic out_free;
  logic proc;
  logic in_accept;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign proc       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    phase_e      ph;
    logic [7:0]  cnt;
    logic [7:0]  cnt_inc;
    logic [7:0]  b;
    logic [27:0] dl;
    logic [7:0]  st;
    logic [39:0] pay;
    logic [47:0] hw;
    logic [15:0] tl;
    logic        fin_meta;

    b = byte_q;
    // start of file restarts from the reset state before this byte is parsed
    ph      = sof_q ? PH_HEADER : phase_q;
    cnt     = sof_q ? 8'd0 : cnt_q;
    cnt_inc = cnt + 8'd1;
    dl      = sof_q ? 28'd0 : delta_q;
    st      = sof_q ? 8'd0 : status_q;
    pay     = sof_q ? 40'd0 : pay_q;
    hw      = sof_q ? 48'd0 : hw_q;
    tl      = sof_q ? 16'd0 : tleft_q;

    phase_d = ph;
    cnt_d   = cnt;
    id_ok_d = sof_q ? 1'b1 : id_ok_q;
    delta_d = dl;
    status_d = st;
    data1_d = sof_q ? 8'd0 : data1_q;
    mlen_d  = sof_q ? 8'd0 : mlen_q;
    pay_d   = pay;
    clen_d  = sof_q ? 32'd0 : clen_q;
    hw_d    = hw;
    tleft_d = tl;

    emit       = 1'b0;
    fin_meta   = 1'b0;
    kind_d     = KIND_HEADER;
    o_delta_d  = '0;
    o_status_d = '0;
    o_data1_d  = '0;
    o_data2_d  = '0;
    o_mlen_d   = '0;
    o_pay_d    = '0;
    o_clen_d   = '0;
    o_fmt_d    = '0;
    o_ntrk_d   = '0;
    o_div_d    = '0;
    o_err_d    = ERR_NONE;

    unique case (ph)
      PH_HEADER: begin
        if (cnt < 8'd4) begin
          if (b != HDR_ID[cnt[1:0]]) begin
            id_ok_d = 1'b0;
          end
        end else if (cnt >= 8'd8) begin
          hw_d = {hw[39:0], b};
        end
        if (cnt_inc < 8'd14) begin
          cnt_d = cnt_inc;
        end else begin
          emit     = 1'b1;
          kind_d   = KIND_HEADER;
          o_fmt_d  = hw_d[47:32];
          o_ntrk_d = hw_d[31:16];
          o_div_d  = hw_d[15:0];
          if (!id_ok_d) begin
            o_err_d = ERR_BAD_ID;
          end else if ((hw_d[47:32] == 16'd0 && hw_d[31:16] > 16'd1) ||
                       (hw_d[47:32] == 16'd1 && hw_d[31:16] < 16'd2)) begin
            o_err_d = ERR_FMT_TRACKS;
          end
          tleft_d = hw_d[31:16];
          cnt_d   = 8'd0;
          clen_d  = 32'd0;
          phase_d = (hw_d[31:16] != 16'd0) ? PH_TRACK : PH_DONE;
        end
      end
      PH_TRACK: begin
        if (cnt >= 8'd4) begin
          clen_d = {clen_q[23:0], b};
        end
        if (cnt_inc < 8'd8) begin
          cnt_d = cnt_inc;
        end else begin
          emit     = 1'b1;
          kind_d   = KIND_TRACK_START;
          o_clen_d = clen_d;
          phase_d  = PH_DELTA;
          cnt_d    = 8'd0;
          delta_d  = 28'd0;
        end
      end
      PH_DELTA: begin
        delta_d = {dl[20:0], b[6:0] & VLQ_MASK[6:0]};
        cnt_d   = cnt_inc;
        if (b[7]) begin
          if (cnt_inc >= 8'(DELTA_MAX_BYTES)) begin
            emit    = 1'b1;
            kind_d  = KIND_ERROR;
            o_err_d = ERR_LONG_DELTA;
            phase_d = PH_HALT;
          end
        end else begin
          phase_d = PH_STATUS;
        end
      end
      PH_STATUS: begin
        status_d = b;
        if (b == ST_META) begin
          phase_d = PH_META_TYPE;
        end else if (b == ST_SYSEX || b == ST_SYSEX_ESC) begin
          emit       = 1'b1;
          kind_d     = KIND_ERROR;
          o_delta_d  = dl;
          o_status_d = b;
          o_err_d    = ERR_SYSEX;
          phase_d    = PH_HALT;
        end else if (b[7:5] == 3'b100 || b[7:4] == 4'hB || b[7:4] == 4'hC) begin
          // note off/on, control change, program change
          phase_d = PH_DATA1;
        end else begin
          emit       = 1'b1;
          kind_d     = KIND_ERROR;
          o_delta_d  = dl;
          o_status_d = b;
          o_err_d    = ERR_BAD_STATUS;
          phase_d    = PH_HALT;
        end
      end
      PH_DATA1: begin
        data1_d = b;
        if (st[7:4] == 4'hC) begin
          emit       = 1'b1;
          kind_d     = KIND_CHANNEL;
          o_delta_d  = dl;
          o_status_d = st;
          o_data1_d  = b;
          phase_d    = PH_DELTA;
          cnt_d      = 8'd0;
          delta_d    = 28'd0;
        end else begin
          phase_d = PH_DATA2;
        end
      end
      PH_DATA2: begin
        emit       = 1'b1;
        kind_d     = KIND_CHANNEL;
        o_delta_d  = dl;
        o_status_d = st;
        o_data1_d  = data1_d;
        o_data2_d  = b;
        phase_d    = PH_DELTA;
        cnt_d      = 8'd0;
        delta_d    = 28'd0;
      end
      PH_META_TYPE: begin
        status_d = b;
        if (!meta_known(b)) begin
          emit       = 1'b1;
          kind_d     = KIND_ERROR;
          o_delta_d  = dl;
          o_status_d = b;
          o_err_d    = ERR_UNKNOWN_META;
          phase_d    = PH_HALT;
        end else begin
          phase_d = PH_META_LEN;
        end
      end
      PH_META_LEN: begin
        mlen_d = b;
        pay_d  = 40'd0;
        cnt_d  = 8'd0;
        if (b == 8'd0) begin
          fin_meta = 1'b1;
        end else begin
          phase_d = PH_META_PAY;
        end
      end
      PH_META_PAY: begin
        if (cnt < 8'(PAYLOAD_HEAD_BYTES)) begin
          pay_d = {pay[31:0], b};
        end
        cnt_d = cnt_inc;
        if (cnt_inc == mlen_d) begin
          fin_meta = 1'b1;
        end
      end
      PH_DONE, PH_HALT: begin
      end
      default: begin
      end
    endcase

    if (fin_meta) begin
      emit       = 1'b1;
      kind_d     = (st == META_EOT) ? KIND_END_TRACK : KIND_META;
      o_delta_d  = dl;
      o_status_d = st;
      o_mlen_d   = mlen_d;
      o_pay_d    = pay_d;
      if (st == META_EOT) begin
        tleft_d = tl - 16'd1;
        cnt_d   = 8'd0;
        clen_d  = 32'd0;
        phase_d = (tleft_d != 16'd0) ? PH_TRACK : PH_DONE;
      end else begin
        phase_d = PH_DELTA;
        cnt_d   = 8'd0;
        delta_d = 28'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_HEADER;
      cnt_q       <= 8'd0;
      id_ok_q     <= 1'b1;
      delta_q     <= 28'd0;
      status_q    <= 8'd0;
      data1_q     <= 8'd0;
      mlen_q      <= 8'd0;
      pay_q       <= 40'd0;
      clen_q      <= 32'd0;
      hw_q        <= 48'd0;
      tleft_q     <= 16'd0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= proc && emit;
      end
      if (proc) begin
        phase_q  <= phase_d;
        cnt_q    <= cnt_d;
        id_ok_q  <= id_ok_d;
        delta_q  <= delta_d;
        status_q <= status_d;
        data1_q  <= data1_d;
        mlen_q   <= mlen_d;
        pay_q    <= pay_d;
        clen_q   <= clen_d;
        hw_q     <= hw_d;
        tleft_q  <= tleft_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
      sof_q  <= start_of_file_i;
    end
    if (proc && emit) begin
      kind_q     <= kind_d;
      o_delta_q  <= o_delta_d;
      o_status_q <= o_status_d;
      o_data1_q  <= o_data1_d;
      o_data2_q  <= o_data2_d;
      o_mlen_q   <= o_mlen_d;
      o_pay_q    <= o_pay_d;
      o_clen_q   <= o_clen_d;
      o_fmt_q    <= o_fmt_d;
      o_ntrk_q   <= o_ntrk_d;
      o_div_q    <= o_div_d;
      o_err_q    <= o_err_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign record_kind_o   = kind_q;
  assign delta_time_o    = o_delta_q;
  assign status_code_o   = o_status_q;
  assign data_first_o    = o_data1_q;
  assign data_second_o   = o_data2_q;
  assign meta_length_o   = o_mlen_q;
  assign payload_head_o  = o_pay_q;
  assign chunk_length_o  = o_clen_q;
  assign file_format_o   = o_fmt_q;
  assign track_count_o   = o_ntrk_q;
  assign tick_division_o = o_div_q;
  assign error_code_o    = o_err_q;

endmodule
